@@ design/jbr_pkg.sv @@
// Shared types and constants of the ring jitter buffer.
package jbr_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned PtrW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned PayloadW  = 64;
  localparam int unsigned LenW      = 16;
  localparam int unsigned LatW      = 5;
  localparam int unsigned FillW     = 5;
  localparam int unsigned CmpW      = (CntW > LatW) ? CntW : LatW;
  localparam logic [LatW-1:0] LatencyReset = LatW'(8);

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_PULL    = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_REFUSED = 2'd2
  } status_e;

  typedef struct packed {
    func_e               func;
    logic [63:0]         payload_in;
    logic [LenW-1:0]     length_in;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [63:0]         payload_out;
    logic [LenW-1:0]     length_out;
    logic                slot_valid;
    logic [FillW-1:0]    fill_level;
    logic                priming;
  } out_item_t;

endpackage

@@ design/jitter_buffer_ring_top.sv @@
// Ring jitter buffer with fill hysteresis: slot store, pointers, flags and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one operation per
//   item: push stores a payload and length, pull peeks at the read slot, release
//   frees the read slot once the buffer is primed.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns one result item
//   per operation, in order: status, peeked slot contents, fill level, priming flag.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes latency_level;
//   it is always ready and should only be written while no item is in flight.
// Result: the result appears in the output register in the cycle after acceptance.
// Throughput: one item per cycle unless stalled; the slot array is read at the read
//   pointer, written at one pointer per cycle; the state update closes in that cycle.
// Reset: all slots free, pointers and fill count zero, priming set, overflow clear,
//   latency_level back to 8. No clearing pass is needed; items are taken at once.
// Stall: while a result waits with out_ready_i low, in_ready_o is low and the
//   result holds; the buffer state does not move.
module jitter_buffer_ring_top
  import jbr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [LatW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  logic [Depth-1:0]    slot_used_q, slot_used_d;
  logic [PayloadW-1:0] slot_payload_q [Depth];
  logic [LenW-1:0]     slot_length_q  [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic                priming_q, priming_d;
  logic                overflow_q, overflow_d;
  logic [LatW-1:0]     latency_q;
  logic                out_valid_q;
  out_item_t           out_q, out_d;
  logic                accept;
  logic                store;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    slot_used_d = slot_used_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    priming_d   = priming_q;
    overflow_d  = overflow_q;
    store       = 1'b0;
    out_d       = '0;
    out_d.status = STATUS_DONE;
    unique case (in_data_i.func)
      FUNC_PUSH: begin
        if (!overflow_q && !slot_used_q[wr_ptr_q]) begin
          store                 = 1'b1;
          slot_used_d[wr_ptr_q] = 1'b1;
          wr_ptr_d              = advance(wr_ptr_q);
          fill_d                = fill_q + 1'b1;
          if (CmpW'(fill_d) >= CmpW'(latency_q)) begin
            priming_d = 1'b0;
          end
        end else begin
          overflow_d   = 1'b1;
          out_d.status = STATUS_DROPPED;
        end
      end
      FUNC_PULL: begin
        if (slot_used_q[rd_ptr_q]) begin
          out_d.payload_out = 64'(slot_payload_q[rd_ptr_q]);
          out_d.length_out  = slot_length_q[rd_ptr_q];
          out_d.slot_valid  = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (!priming_q && slot_used_q[rd_ptr_q]) begin
          slot_used_d[rd_ptr_q] = 1'b0;
          rd_ptr_d              = advance(rd_ptr_q);
          if (fill_q != '0) begin
            fill_d = fill_q - 1'b1;
          end
          if (fill_d == '0) begin
            priming_d = 1'b1;
          end
          if (CmpW'(fill_d) <= CmpW'(latency_q)) begin
            overflow_d = 1'b0;
          end
        end else begin
          out_d.status = STATUS_REFUSED;
        end
      end
      default: begin
        // unused code: no state change
      end
    endcase
    out_d.fill_level = FillW'(fill_d);
    out_d.priming    = priming_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      priming_q   <= 1'b1;
      overflow_q  <= 1'b0;
      latency_q   <= LatencyReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        latency_q <= cfg_data_i;
      end
      if (accept) begin
        slot_used_q <= slot_used_d;
        wr_ptr_q    <= wr_ptr_d;
        rd_ptr_q    <= rd_ptr_d;
        fill_q      <= fill_d;
        priming_q   <= priming_d;
        overflow_q  <= overflow_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot contents and the result need no reset; empty slots read as zero via the used bits.
  always_ff @(posedge clk_i) begin
    if (accept && store) begin
      slot_payload_q[wr_ptr_q] <= PayloadW'(in_data_i.payload_in);
      slot_length_q[wr_ptr_q]  <= in_data_i.length_in;
    end
    if (accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  a_fill_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_used_q) == 32'(fill_q))
    else $error("fill count differs from number of used slots");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= Depth)
    else $error("fill count above depth");

  a_primed_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !priming_q |-> fill_q != '0)
    else $error("primed with an empty buffer");

  a_full_ptrs_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fill_q) == Depth) |-> (wr_ptr_q == rd_ptr_q))
    else $error("full buffer with pointers apart");
`endif

endmodule
